// ===== design/char_lcd_nibble_sequencer_macros.svh =====
// Assertion macros shared by the character LCD nibble sequencer.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_MACROS_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_MACROS_SVH

`ifndef ASSERT_OFF

// The condition holds at every clock edge out of reset.
`define CLNS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define CLNS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define CLNS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CLNS_ASSERT_ALWAYS(lbl, cond, msg)
`define CLNS_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define CLNS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== design/clns_pkg.sv =====
// Types, constants and tables shared by the character LCD nibble sequencer.
package clns_pkg;

  // Request kinds.
  localparam logic [1:0] REQ_INIT   = 2'd0;
  localparam logic [1:0] REQ_CMD    = 2'd1;
  localparam logic [1:0] REQ_DATA   = 2'd2;
  localparam logic [1:0] REQ_CURSOR = 2'd3;

  // Bit positions on the port expander.
  localparam int RS_BIT        = 0;
  localparam int ENABLE_BIT    = 2;
  localparam int BACKLIGHT_BIT = 3;

  // Controller commands used by the init sequence and cursor moves.
  localparam logic [3:0] NIB_WAKE       = 4'h3;
  localparam logic [3:0] NIB_FOUR_BIT   = 4'h2;
  localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
  localparam logic [7:0] CMD_DISP_ON    = 8'h0C;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;
  localparam logic [7:0] LINE2_BASE     = 8'h40;
  localparam logic [7:0] COL_MAX        = 8'h0F;

  // Nibble indexes of the last nibble of each request shape.
  localparam logic [3:0] INIT_LAST_IDX = 4'd11;
  localparam logic [3:0] BYTE_LAST_IDX = 4'd1;

  // Wait times in microseconds.
  localparam logic [14:0] WAIT_POWER_UP = 15'd20000;
  localparam logic [12:0] WAIT_PULSE    = 13'd1;
  localparam logic [12:0] WAIT_CMD      = 13'd50;
  localparam logic [12:0] WAIT_WAKE1    = 13'd5050;
  localparam logic [12:0] WAIT_WAKE2    = 13'd150;
  localparam logic [12:0] WAIT_CLEAR    = 13'd2050;

  // Which wait follows the enable-clear write of a nibble.
  typedef enum logic [1:0] {
    WC_CMD   = 2'd0,
    WC_WAKE1 = 2'd1,
    WC_WAKE2 = 2'd2,
    WC_CLEAR = 2'd3
  } wait_code_t;

  // One request as it arrives.
  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] value;
    logic [7:0] row;
    logic [7:0] col;
  } lcd_req_t;

  // One write to the port expander.
  typedef struct packed {
    logic [7:0]  expander_byte;
    logic [14:0] wait_before_us;
    logic [12:0] wait_after_us;
    logic        last;
  } lcd_write_t;

  // One nibble queued between the front and the back end.
  typedef struct packed {
    logic [3:0] nib;
    logic       rs;
    logic       first;
    wait_code_t wcode;
    logic       last;
  } nib_entry_t;

  // Queue status seen by both ends.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Nibble sequence of the init request.
  function automatic logic [3:0] init_nibble(input logic [3:0] idx);
    logic [3:0] n;
    case (idx)
      4'd0, 4'd1, 4'd2: n = NIB_WAKE;
      4'd3:  n = NIB_FOUR_BIT;
      4'd4:  n = CMD_FUNC_SET[7:4];
      4'd5:  n = CMD_FUNC_SET[3:0];
      4'd6:  n = CMD_DISP_ON[7:4];
      4'd7:  n = CMD_DISP_ON[3:0];
      4'd8:  n = CMD_ENTRY_MODE[7:4];
      4'd9:  n = CMD_ENTRY_MODE[3:0];
      4'd10: n = CMD_CLEAR[7:4];
      4'd11: n = CMD_CLEAR[3:0];
      default: n = 4'h0;
    endcase
    return n;
  endfunction

endpackage

// ===== design/clns_front.sv =====
// Front end: accepts requests and turns each into a series of queued nibbles.
module clns_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  clns_pkg::lcd_req_t   in_data,
  input  clns_pkg::q_status_t  q_stat,
  output logic                 q_push,
  output clns_pkg::nib_entry_t q_entry
);
  import clns_pkg::*;

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_RUN  = 2'b10
  } front_state_t;

  front_state_t state_r, state_nxt;
  logic         init_r, init_nxt;
  logic         rs_r, rs_nxt;
  logic [7:0]   byte_r, byte_nxt;
  logic [3:0]   idx_r, idx_nxt;
  logic         accept;
  logic         last_nib;
  logic [7:0]   cursor_byte;
  logic [7:0]   col_clamped;

  assign busy   = (state_r != F_IDLE);
  assign accept = start && (state_r == F_IDLE);
  assign q_push = (state_r == F_RUN) && !q_stat.full;

  // Cursor address: clamp row and column, then add the line base.
  always_comb begin
    col_clamped = (in_data.col > COL_MAX) ? COL_MAX : in_data.col;
    cursor_byte = CMD_SET_DDRAM | ((in_data.row != 8'd0) ? LINE2_BASE : 8'd0) | col_clamped;
  end

  // Build the nibble entry for the current index.
  always_comb begin
    last_nib = init_r ? (idx_r == INIT_LAST_IDX) : (idx_r == BYTE_LAST_IDX);
    q_entry.nib   = init_r ? init_nibble(idx_r) : (idx_r[0] ? byte_r[3:0] : byte_r[7:4]);
    q_entry.rs    = rs_r;
    q_entry.first = init_r && (idx_r == 4'd0);
    q_entry.last  = last_nib;
    q_entry.wcode = WC_CMD;
    if (init_r) begin
      case (idx_r)
        4'd0:          q_entry.wcode = WC_WAKE1;
        4'd1:          q_entry.wcode = WC_WAKE2;
        INIT_LAST_IDX: q_entry.wcode = WC_CLEAR;
        default:       q_entry.wcode = WC_CMD;
      endcase
    end
  end

  // Request capture and nibble stepping.
  always_comb begin
    state_nxt = state_r;
    init_nxt  = init_r;
    rs_nxt    = rs_r;
    byte_nxt  = byte_r;
    idx_nxt   = idx_r;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          state_nxt = F_RUN;
          idx_nxt   = 4'd0;
          init_nxt  = (in_data.req_type == REQ_INIT);
          rs_nxt    = (in_data.req_type == REQ_DATA);
          case (in_data.req_type)
            REQ_CURSOR: byte_nxt = cursor_byte;
            default:    byte_nxt = in_data.value;
          endcase
        end
      end
      F_RUN: begin
        if (q_push) begin
          if (last_nib) begin
            state_nxt = F_IDLE;
          end else begin
            idx_nxt = idx_r + 4'd1;
          end
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    init_r <= init_nxt;
    rs_r   <= rs_nxt;
    byte_r <= byte_nxt;
    idx_r  <= idx_nxt;
  end

endmodule

// ===== design/clns_queue.sv =====
// Short nibble queue that decouples the front end from the back end.
module clns_queue #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  clns_pkg::nib_entry_t push_entry,
  input  logic                 pop,
  output clns_pkg::nib_entry_t head,
  output clns_pkg::q_status_t  stat
);
  import clns_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  nib_entry_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== design/clns_back.sv =====
// Back end: sends each queued nibble as an enable-set and an enable-clear write.
module clns_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  clns_pkg::nib_entry_t head,
  input  clns_pkg::q_status_t  q_stat,
  output logic                 q_pop,
  output logic                 out_valid,
  output clns_pkg::lcd_write_t out_data
);
  import clns_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_SET  = 3'b010,
    B_CLR  = 3'b100
  } back_state_t;

  back_state_t state_r, state_nxt;
  nib_entry_t  ent_r, ent_nxt;
  logic        out_valid_r, out_valid_nxt;
  lcd_write_t  out_data_r, out_data_nxt;
  logic [7:0]  base_byte;

  // A new nibble is taken when idle or on the second write of the current one.
  assign q_pop = ((state_r == B_IDLE) || (state_r == B_CLR)) && !q_stat.empty;

  always_comb begin
    state_nxt = state_r;
    ent_nxt   = ent_r;
    case (state_r)
      B_IDLE, B_CLR: begin
        if (!q_stat.empty) begin
          state_nxt = B_SET;
          ent_nxt   = head;
        end else begin
          state_nxt = B_IDLE;
        end
      end
      B_SET:   state_nxt = B_CLR;
      default: state_nxt = B_IDLE;
    endcase
  end

  // Assemble the expander write for the current phase.
  always_comb begin
    base_byte                = {ent_r.nib, 4'h0};
    base_byte[BACKLIGHT_BIT] = 1'b1;
    base_byte[RS_BIT]        = ent_r.rs;
    out_valid_nxt = (state_r == B_SET) || (state_r == B_CLR);
    out_data_nxt.expander_byte  = base_byte;
    out_data_nxt.wait_before_us = 15'd0;
    out_data_nxt.wait_after_us  = WAIT_CMD;
    out_data_nxt.last           = 1'b0;
    if (state_r == B_SET) begin
      out_data_nxt.expander_byte[ENABLE_BIT] = 1'b1;
      out_data_nxt.wait_before_us = ent_r.first ? WAIT_POWER_UP : 15'd0;
      out_data_nxt.wait_after_us  = WAIT_PULSE;
    end else begin
      out_data_nxt.expander_byte[ENABLE_BIT] = 1'b0;
      out_data_nxt.last = ent_r.last;
      case (ent_r.wcode)
        WC_WAKE1: out_data_nxt.wait_after_us = WAIT_WAKE1;
        WC_WAKE2: out_data_nxt.wait_after_us = WAIT_WAKE2;
        WC_CLEAR: out_data_nxt.wait_after_us = WAIT_CLEAR;
        default:  out_data_nxt.wait_after_us = WAIT_CMD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ent_r      <= ent_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/char_lcd_nibble_sequencer.sv =====
// Top level of the character LCD nibble sequencer.
// Turns init, command, data and set-cursor requests into port expander writes for a
// 4-bit character LCD. A request transfer takes place when start is high and busy is
// low. Results appear on out_data for exactly one cycle each, flagged by out_valid,
// and cannot be held off. The back end sends one write per cycle while the queue holds
// nibbles, two per nibble, so a command, data or cursor request yields four writes and
// init yields twenty-four; the first write passes through the front end's registers,
// the queue and the back end's state and output registers. The front end pushes one
// nibble a cycle into the queue while it is not full and frees busy once its last
// nibble is queued, so new requests are taken while the back end still sends writes.
`include "char_lcd_nibble_sequencer_macros.svh"

module char_lcd_nibble_sequencer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  clns_pkg::lcd_req_t   in_data,
  output logic                 out_valid,
  output clns_pkg::lcd_write_t out_data
);
  import clns_pkg::*;

  nib_entry_t q_entry;
  nib_entry_t q_head;
  q_status_t  q_stat;
  logic       q_push;
  logic       q_pop;
  logic       wr_en_set;
  logic       wr_en_clr;
  logic       wr_pre_wait;
  logic       wr_pre_wait_ok;

  // Request intake and nibble generation.
  clns_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_data (in_data),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  // Nibble queue between the two ends.
  clns_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .stat       (q_stat)
  );

  // Expander write sequencing.
  clns_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Properties of the write currently on the result ports.
  assign wr_en_set      = out_valid && out_data.expander_byte[ENABLE_BIT];
  assign wr_en_clr      = out_valid && !out_data.expander_byte[ENABLE_BIT];
  assign wr_pre_wait    = out_valid && (out_data.wait_before_us != 15'd0);
  assign wr_pre_wait_ok = wr_en_set && (out_data.wait_before_us == WAIT_POWER_UP);

  // The front end never pushes into a full queue.
  `CLNS_ASSERT_IMPLIES(a_no_push_full, q_push, !q_stat.full, "push into full queue")
  // Every enable-set write is followed at once by its enable-clear write.
  `CLNS_ASSERT_NEXT(a_pulse_pair, wr_en_set, wr_en_clr, "enable pulse not closed")
  // Only the first init write carries a wait before it.
  `CLNS_ASSERT_IMPLIES(a_wait_before, wr_pre_wait, wr_pre_wait_ok, "unexpected wait before write")

endmodule

// ===== test/char_lcd_nibble_sequencer_tb.sv =====
// Self-checking testbench for the character LCD nibble sequencer top level.
`timescale 1ns / 1ps

module char_lcd_nibble_sequencer_tb;
  import clns_pkg::*;

  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 6;
  localparam int RANDOM_REQUESTS = 410;
  localparam int CYCLE_LIMIT     = 300000;
  localparam int DRAIN_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 8;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic       out_valid;
  lcd_req_t   in_data;
  lcd_write_t out_data;

  // Writes predicted for the request being worked out, and all writes still owed.
  lcd_write_t request_writes[$];
  lcd_write_t pending_writes[$];

  int errors         = 0;
  int writes_checked = 0;
  int cycle_count    = 0;
  int reqs_by_kind[4];

  char_lcd_nibble_sequencer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Two writes per nibble: enable set with a short pulse wait, then enable cleared.
  function automatic void add_nibble(input logic [3:0] nib, input logic rs,
                                     input wait_code_t wc);
    lcd_write_t w;
    logic [7:0] base;
    base                = {nib, 4'h0};
    base[BACKLIGHT_BIT] = 1'b1;
    base[RS_BIT]        = rs;
    w.expander_byte             = base;
    w.expander_byte[ENABLE_BIT] = 1'b1;
    w.wait_before_us            = '0;
    w.wait_after_us             = WAIT_PULSE;
    w.last                      = 1'b0;
    request_writes.push_back(w);
    w.expander_byte[ENABLE_BIT] = 1'b0;
    case (wc)
      WC_WAKE1: w.wait_after_us = WAIT_WAKE1;
      WC_WAKE2: w.wait_after_us = WAIT_WAKE2;
      WC_CLEAR: w.wait_after_us = WAIT_CLEAR;
      default:  w.wait_after_us = WAIT_CMD;
    endcase
    request_writes.push_back(w);
  endfunction

  // A byte goes out high nibble first.
  function automatic void add_byte(input logic [7:0] b, input logic rs);
    add_nibble(b[7:4], rs, WC_CMD);
    add_nibble(b[3:0], rs, WC_CMD);
  endfunction

  // Works out every write that one request causes and queues them as owed.
  function automatic void predict_writes(input lcd_req_t rq);
    logic [7:0] row_c;
    logic [7:0] col_c;
    logic [7:0] addr;
    request_writes.delete();
    case (rq.req_type)
      REQ_INIT: begin
        add_nibble(NIB_WAKE, 1'b0, WC_WAKE1);
        add_nibble(NIB_WAKE, 1'b0, WC_WAKE2);
        add_nibble(NIB_WAKE, 1'b0, WC_CMD);
        add_nibble(NIB_FOUR_BIT, 1'b0, WC_CMD);
        add_byte(CMD_FUNC_SET, 1'b0);
        add_byte(CMD_DISP_ON, 1'b0);
        add_byte(CMD_ENTRY_MODE, 1'b0);
        add_nibble(CMD_CLEAR[7:4], 1'b0, WC_CMD);
        add_nibble(CMD_CLEAR[3:0], 1'b0, WC_CLEAR);
        request_writes[0].wait_before_us = WAIT_POWER_UP;
      end
      REQ_CMD:  add_byte(rq.value, 1'b0);
      REQ_DATA: add_byte(rq.value, 1'b1);
      default: begin
        // Rows past the second line and columns past the last one are clamped.
        row_c = (rq.row > 8'd1) ? 8'd1 : rq.row;
        col_c = (rq.col > COL_MAX) ? COL_MAX : rq.col;
        addr  = ((row_c == 8'd0) ? 8'h00 : LINE2_BASE) + col_c;
        add_byte(CMD_SET_DDRAM | addr, 1'b0);
      end
    endcase
    request_writes[request_writes.size() - 1].last = 1'b1;
    foreach (request_writes[i]) pending_writes.push_back(request_writes[i]);
  endfunction

  function automatic lcd_req_t make_request(input logic [1:0] kind, input logic [7:0] value,
                                            input logic [7:0] row, input logic [7:0] col);
    lcd_req_t rq;
    rq.req_type = kind;
    rq.value    = value;
    rq.row      = row;
    rq.col      = col;
    return rq;
  endfunction

  // Mostly byte requests, a few inits, and cursor moves with both small and wild positions.
  function automatic lcd_req_t random_request();
    int         pick;
    logic [1:0] kind;
    logic [7:0] row;
    logic [7:0] col;
    pick = $urandom_range(0, 99);
    if (pick < 3)       kind = REQ_INIT;
    else if (pick < 35) kind = REQ_CMD;
    else if (pick < 75) kind = REQ_DATA;
    else                kind = REQ_CURSOR;
    row = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    col = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 20)) : 8'($urandom);
    return make_request(kind, 8'($urandom), row, col);
  endfunction

  // Mostly no gap or a short one, now and then a long one.
  function automatic int random_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55)      return 0;
    else if (pick < 88) return $urandom_range(1, 3);
    else                return $urandom_range(8, 40);
  endfunction

  // Offers one request and holds it until the transfer takes place.
  task automatic send_request(input lcd_req_t rq);
    @(negedge clk);
    start   <= 1'b1;
    in_data <= rq;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_writes(rq);
    reqs_by_kind[rq.req_type]++;
  endtask

  task automatic idle_for(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // The power-up sequence, back to back and straight after a byte request.
  task automatic test_init();
    send_request(make_request(REQ_INIT, 8'hFF, 8'hFF, 8'hFF));
    send_request(make_request(REQ_INIT, 8'h00, 8'h00, 8'h00));
    send_request(make_request(REQ_CMD, 8'h33, 8'h00, 8'h00));
    send_request(make_request(REQ_INIT, 8'hA5, 8'h5A, 8'hC3));
    idle_for(3);
  endtask

  // Command and data bytes at the extremes; row and column must have no effect.
  task automatic test_byte_extremes();
    send_request(make_request(REQ_CMD, 8'h00, 8'hFF, 8'hFF));
    send_request(make_request(REQ_CMD, 8'hFF, 8'h00, 8'h00));
    send_request(make_request(REQ_DATA, 8'h00, 8'hFF, 8'h00));
    send_request(make_request(REQ_DATA, 8'hFF, 8'h00, 8'hFF));
    idle_for(2);
    send_request(make_request(REQ_DATA, 8'h5A, 8'hAA, 8'h55));
    send_request(make_request(REQ_DATA, 8'hA5, 8'h55, 8'hAA));
    send_request(make_request(REQ_CMD, 8'h81, 8'h01, 8'h0F));
    idle_for(5);
  endtask

  // Cursor moves at the corners of the display and past them; value must have no effect.
  task automatic test_cursor_clamp();
    send_request(make_request(REQ_CURSOR, 8'hFF, 8'd0, 8'd0));
    send_request(make_request(REQ_CURSOR, 8'h00, 8'd0, 8'd15));
    send_request(make_request(REQ_CURSOR, 8'hFF, 8'd1, 8'd0));
    send_request(make_request(REQ_CURSOR, 8'h00, 8'd1, 8'd15));
    send_request(make_request(REQ_CURSOR, 8'h5A, 8'd2, 8'd16));
    send_request(make_request(REQ_CURSOR, 8'hA5, 8'd255, 8'd255));
    send_request(make_request(REQ_CURSOR, 8'hFF, 8'd0, 8'd255));
    send_request(make_request(REQ_CURSOR, 8'h00, 8'd255, 8'd0));
    idle_for(4);
  endtask

  // Random requests; every third stretch of forty is sent with no gaps at all.
  task automatic test_random();
    lcd_req_t rq;
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      rq = random_request();
      send_request(rq);
      if ((i / 40) % 3 != 2) idle_for(random_gap());
    end
  endtask

  // Each write is compared with the oldest one still owed.
  always @(posedge clk) begin : check_writes
    lcd_write_t want;
    if (rst_n && out_valid) begin
      if (pending_writes.size() == 0) begin
        errors++;
        $display("%0t: write with none owed: byte=%h before=%0d after=%0d last=%b",
                 $time, out_data.expander_byte, out_data.wait_before_us,
                 out_data.wait_after_us, out_data.last);
      end else begin
        want = pending_writes.pop_front();
        writes_checked++;
        if (out_data !== want) begin
          errors++;
          $display("%0t: mismatch expected byte=%h before=%0d after=%0d last=%b", $time,
                   want.expander_byte, want.wait_before_us, want.wait_after_us, want.last);
          $display("%0t:          actual   byte=%h before=%0d after=%0d last=%b", $time,
                   out_data.expander_byte, out_data.wait_before_us,
                   out_data.wait_after_us, out_data.last);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run stopped by the cycle limit", $time);
      $display("** char_lcd_nibble_sequencer: FAILED **");
      $finish;
    end
  end

  // Reset once, then each test in turn, then drain and report.
  initial begin
    int waited;
    foreach (reqs_by_kind[k]) reqs_by_kind[k] = 0;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_init();
    test_byte_extremes();
    test_cursor_clamp();
    test_random();

    // Wait for every owed write, then let the bench settle to catch stray writes.
    idle_for(1);
    waited = 0;
    while (pending_writes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_writes.size() != 0) begin
      errors += pending_writes.size();
      $display("%0t: %0d writes never arrived", $time, pending_writes.size());
    end

    $display("Sent %0d init, %0d command, %0d data and %0d cursor requests.",
             reqs_by_kind[REQ_INIT], reqs_by_kind[REQ_CMD], reqs_by_kind[REQ_DATA],
             reqs_by_kind[REQ_CURSOR]);
    $display("Checked %0d expander writes; %0d errors.", writes_checked, errors);
    if (errors == 0) begin
      $display("** char_lcd_nibble_sequencer: PASSED **");
    end else begin
      $display("** char_lcd_nibble_sequencer: FAILED **");
    end
    $finish;
  end

endmodule
